// ----- src/qmi_pkg.sv -----
// Shared widths, command and status codes for the middle-insert queue.
package qmi_pkg;

   localparam int DATA_W           = 32;
   localparam int CMD_W            = 2;
   localparam int STATUS_W         = 2;
   localparam int CAPACITY_DEFAULT = 1024;

   localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_MIDDLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP         = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ----- src/qmi_ram.sv -----
// Simple dual-port synchronous RAM holding one half of the queue.
module qmi_ram
   import qmi_pkg::*;
#(
   parameter int DEPTH  = CAPACITY_DEFAULT / 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/queue_with_middle_insert.sv -----
// Bounded queue with rear push, middle insert and front pop, kept as two ring halves.
// An accepted request first issues the half-memory reads and writes in the idle state; the
// busy state then lands the rebalancing move into the front half and loads the response register.
// Only pops and rejected pushes load a response; a successful push returns none. Requests are
// not taken while busy, so a new request waits until the last one is through. An unused
// command code returns to idle with no busy state, and a held response keeps the busy state until taken.
// Reset clears state, pointers, counts and the response valid flag; memories and response data are not cleared.
module queue_with_middle_insert
   import qmi_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CMD_W-1:0]           req_command,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [DATA_W-1:0]   rsp_popped_value,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam int FRONT_DEPTH = (CAPACITY + 1) / 2;
   localparam int BACK_DEPTH  = CAPACITY / 2;
   localparam int PTR_FW      = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;
   localparam int PTR_BW      = (BACK_DEPTH > 1) ? $clog2(BACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(FRONT_DEPTH + 1);
   localparam int SUM_W       = CNT_W + 1;
   localparam int N_W         = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [PTR_FW-1:0] f_head_ff, f_head_in;
   logic [PTR_BW-1:0] b_head_ff, b_head_in;
   logic [CNT_W-1:0]  f_cnt_ff, f_cnt_in;
   logic [CNT_W-1:0]  b_cnt_ff, b_cnt_in;

   logic              move_ff, move_in;
   logic              fwd_ff, fwd_in;
   logic [PTR_FW-1:0] move_addr_ff, move_addr_in;
   logic [DATA_W-1:0] push_value_ff, push_value_in;
   logic              res_pend_ff, res_pend_in;
   logic              res_mem_ff, res_mem_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic              f_we, f_re, b_we, b_re;
   logic [PTR_FW-1:0] f_waddr;
   logic [PTR_BW-1:0] b_waddr;
   logic [DATA_W-1:0] f_wdata, b_wdata, f_rdata, b_rdata;

   logic [SUM_W-1:0]  f_sum, b_sum;
   logic [PTR_FW-1:0] f_tail, f_inc;
   logic [PTR_BW-1:0] b_tail, b_inc, b_dec;
   logic [N_W-1:0]    total;
   logic              queue_full;

   // Ring positions derived from the current pointers and counts.
   always_comb begin
      f_sum  = SUM_W'(f_head_ff) + SUM_W'(f_cnt_ff);
      f_tail = (f_sum >= SUM_W'(FRONT_DEPTH)) ? PTR_FW'(f_sum - SUM_W'(FRONT_DEPTH))
                                              : PTR_FW'(f_sum);
      b_sum  = SUM_W'(b_head_ff) + SUM_W'(b_cnt_ff);
      b_tail = (b_sum >= SUM_W'(BACK_DEPTH)) ? PTR_BW'(b_sum - SUM_W'(BACK_DEPTH))
                                             : PTR_BW'(b_sum);
      f_inc  = (f_head_ff == PTR_FW'(FRONT_DEPTH - 1)) ? '0 : f_head_ff + 1'b1;
      b_inc  = (b_head_ff == PTR_BW'(BACK_DEPTH - 1)) ? '0 : b_head_ff + 1'b1;
      b_dec  = (b_head_ff == '0) ? PTR_BW'(BACK_DEPTH - 1) : b_head_ff - 1'b1;
      total  = N_W'(f_cnt_ff) + N_W'(b_cnt_ff);
      queue_full = (total >= N_W'(CAPACITY));
   end

   always_comb begin
      state_in      = state_ff;
      f_head_in     = f_head_ff;
      b_head_in     = b_head_ff;
      f_cnt_in      = f_cnt_ff;
      b_cnt_in      = b_cnt_ff;
      move_in       = move_ff;
      fwd_in        = fwd_ff;
      move_addr_in  = move_addr_ff;
      push_value_in = push_value_ff;
      res_pend_in   = res_pend_ff;
      res_mem_in    = res_mem_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      f_we    = 1'b0;
      f_re    = 1'b0;
      b_we    = 1'b0;
      b_re    = 1'b0;
      f_waddr = f_tail;
      f_wdata = req_value;
      b_waddr = b_tail;
      b_wdata = req_value;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in      = ST_BUSY;
               move_in       = 1'b0;
               fwd_in        = 1'b0;
               move_addr_in  = f_tail;
               push_value_in = req_value;
               res_pend_in   = 1'b0;
               res_mem_in    = 1'b0;
               res_status_in = STATUS_OK;
               case (req_command)
                  CMD_POP: begin
                     res_pend_in = 1'b1;
                     if (f_cnt_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        f_re       = 1'b1;
                        res_mem_in = 1'b1;
                        f_head_in  = f_inc;
                        // The back head refills the slot freed at the front tail.
                        if (b_cnt_ff != '0 && b_cnt_ff >= f_cnt_ff) begin
                           b_re      = 1'b1;
                           b_head_in = b_inc;
                           b_cnt_in  = b_cnt_ff - 1'b1;
                           move_in   = 1'b1;
                        end else begin
                           f_cnt_in = f_cnt_ff - 1'b1;
                        end
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (queue_full) begin
                        res_pend_in   = 1'b1;
                        res_status_in = STATUS_FULL;
                     end else if (b_cnt_ff < CNT_W'(BACK_DEPTH)) begin
                        b_we = 1'b1;
                        if (b_cnt_ff >= f_cnt_ff) begin
                           // When the back half was empty the new value is the one moved.
                           b_re      = 1'b1;
                           fwd_in    = (b_cnt_ff == '0);
                           b_head_in = b_inc;
                           if (f_cnt_ff < CNT_W'(FRONT_DEPTH)) begin
                              move_in  = 1'b1;
                              f_cnt_in = f_cnt_ff + 1'b1;
                           end
                        end else begin
                           b_cnt_in = b_cnt_ff + 1'b1;
                        end
                     end else if (f_cnt_ff < CNT_W'(FRONT_DEPTH)) begin
                        f_we     = 1'b1;
                        f_cnt_in = f_cnt_ff + 1'b1;
                     end
                  end
                  CMD_PUSH_MIDDLE: begin
                     if (queue_full) begin
                        res_pend_in   = 1'b1;
                        res_status_in = STATUS_FULL;
                     end else if (f_cnt_ff == b_cnt_ff) begin
                        if (f_cnt_ff < CNT_W'(FRONT_DEPTH)) begin
                           f_we     = 1'b1;
                           f_cnt_in = f_cnt_ff + 1'b1;
                        end
                     end else begin
                        b_we      = 1'b1;
                        b_waddr   = b_dec;
                        b_head_in = b_dec;
                        b_cnt_in  = b_cnt_ff + 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_BUSY: begin
            if (move_ff) begin
               f_we    = 1'b1;
               f_waddr = move_addr_ff;
               f_wdata = fwd_ff ? push_value_ff : b_rdata;
            end
            if (!res_pend_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_mem_ff ? f_rdata : '0;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         f_head_ff    <= '0;
         b_head_ff    <= '0;
         f_cnt_ff     <= '0;
         b_cnt_ff     <= '0;
         move_ff      <= 1'b0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         f_head_ff    <= f_head_in;
         b_head_ff    <= b_head_in;
         f_cnt_ff     <= f_cnt_in;
         b_cnt_ff     <= b_cnt_in;
         move_ff      <= move_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff        <= fwd_in;
      move_addr_ff  <= move_addr_in;
      push_value_ff <= push_value_in;
      res_mem_ff    <= res_mem_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   qmi_ram #(
      .DEPTH  (FRONT_DEPTH),
      .ADDR_W (PTR_FW)
   ) u_front_ram (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_en   (f_re),
      .rd_addr (f_head_ff),
      .rd_data (f_rdata)
   );

   qmi_ram #(
      .DEPTH  (BACK_DEPTH),
      .ADDR_W (PTR_BW)
   ) u_back_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_en   (b_re),
      .rd_addr (b_head_ff),
      .rd_data (b_rdata)
   );

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_popped_value = $signed(rsp_value_ff);
   assign rsp_status       = rsp_status_ff;

   // The front half always holds as many entries as the back half or exactly one more.
   assert property (@(posedge clock) disable iff (reset)
      (f_cnt_ff == b_cnt_ff) || (f_cnt_ff == CNT_W'(b_cnt_ff + 1'b1)))
      else $error("front and back halves out of balance");

   assert property (@(posedge clock) disable iff (reset)
      total <= N_W'(CAPACITY))
      else $error("queue holds more entries than its capacity");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_popped_value == '0))
      else $error("failed request returned a non-zero value");

   // A pop that empties the front half cannot leave entries in the back half.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_POP && f_cnt_ff == CNT_W'(1))
      |=> (b_cnt_ff == '0))
      else $error("back half left populated behind an empty front half");

endmodule
